[hdl/pfmt_pkg.sv]
// ----------------------------------------------------------------------------
// pfmt_pkg
// Shared types and constants of the integer field formatter.
// ----------------------------------------------------------------------------
package pfmt_pkg;

   localparam logic [2:0] FUNC_SDEC  = 3'd0;
   localparam logic [2:0] FUNC_UDEC  = 3'd1;
   localparam logic [2:0] FUNC_OCT   = 3'd2;
   localparam logic [2:0] FUNC_HEXL  = 3'd3;
   localparam logic [2:0] FUNC_HEXU  = 3'd4;
   localparam logic [2:0] FUNC_PTR   = 3'd5;

   localparam logic [1:0] LEN_INT    = 2'd0;
   localparam logic [1:0] LEN_SHORT  = 2'd1;
   localparam logic [1:0] LEN_LONG   = 2'd2;

   localparam logic [1:0] SMODE_MINUS_ONLY = 2'd0;
   localparam logic [1:0] SMODE_FORCE_PLUS = 2'd1;
   localparam logic [1:0] SMODE_BLANK      = 2'd2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOWX  = 8'h78;
   localparam logic [7:0] CHAR_UPX   = 8'h58;
   localparam logic [7:0] CHAR_ALOW  = 8'h57;  // 'a' - 10
   localparam logic [7:0] CHAR_AUP   = 8'h37;  // 'A' - 10

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_PLAN,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef enum logic [2:0] {
      SEG_PAD_L,
      SEG_SIGN,
      SEG_PREFIX,
      SEG_ZEROS,
      SEG_DIGITS,
      SEG_PAD_R
   } seg_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic plan;
      logic emit_start;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic is_empty;
      logic emit_last;
   } status_type;

endpackage

[hdl/pfmt_if.sv]
// ----------------------------------------------------------------------------
// pfmt_req_if / pfmt_rsp_if
// Valid/ready channels for conversion requests and output characters.
// ----------------------------------------------------------------------------
interface pfmt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [63:0] value;
   logic [1:0]  length_mode;
   logic [6:0]  field_width;
   logic        has_width;
   logic [5:0]  digit_precision;
   logic        has_precision;
   logic [1:0]  sign_mode;
   logic        left_justify;
   logic        zero_pad;
   logic        alt_form;
   modport source (output valid, func, value, length_mode, field_width, has_width,
                   digit_precision, has_precision, sign_mode, left_justify,
                   zero_pad, alt_form, input ready);
   modport sink (input valid, func, value, length_mode, field_width, has_width,
                 digit_precision, has_precision, sign_mode, left_justify,
                 zero_pad, alt_form, output ready);
endinterface

interface pfmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;
   logic       empty_res;
   modport source (output valid, out_char, last, empty_res, input ready);
   modport sink (input valid, out_char, last, empty_res, output ready);
endinterface

[hdl/printf_integer_field_formatter_core.sv]
// The first character can transfer after the request transfer once the nd digits (up to
// 22, one a cycle) are converted and the field planned; decimal first runs binary-to-BCD
// shifting when it prints digits. An empty result can transfer after conversion and plan.
// Throughput: one character per cycle while rsp.ready is high, up to 64; one request
// at a time, the next one transferring at the earliest after the last character transfer.
// Reset is synchronous, active high, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// printf_integer_field_formatter_core
// Formats one integer conversion request into a stream of characters.
// ----------------------------------------------------------------------------
module printf_integer_field_formatter_core #(
   parameter int MAX_WIDTH     = 64,
   parameter int MAX_PRECISION = 60
) (
   input  logic  clock,
   input  logic  reset,
   pfmt_req_if.sink   req,
   pfmt_rsp_if.source rsp
);

   pfmt_pkg::cmd_type    cmd;
   pfmt_pkg::status_type status;
   logic [7:0]           char_w;
   logic                 empty_w;

   pfmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .empty_out (empty_w),
      .cmd       (cmd),
      .status    (status)
   );

   pfmt_datapath #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_PRECISION (MAX_PRECISION)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req.func),
      .req_value           (req.value),
      .req_length_mode     (req.length_mode),
      .req_field_width     (req.field_width),
      .req_has_width       (req.has_width),
      .req_digit_precision (req.digit_precision),
      .req_has_precision   (req.has_precision),
      .req_sign_mode       (req.sign_mode),
      .req_left_justify    (req.left_justify),
      .req_zero_pad        (req.zero_pad),
      .req_alt_form        (req.alt_form),
      .char_out            (char_w)
   );

   assign rsp.out_char  = empty_w ? 8'd0 : char_w;
   assign rsp.empty_res = empty_w;
   assign rsp.last      = empty_w | status.emit_last;

endmodule

[hdl/pfmt_datapath.sv]
// ----------------------------------------------------------------------------
// pfmt_datapath
// Digit conversion (binary-to-BCD shifting for decimal, then one digit per
// cycle into a digit store) and the segment sequencer that produces one
// output character per step.
// ----------------------------------------------------------------------------
module pfmt_datapath #(
   parameter int MAX_WIDTH     = 64,
   parameter int MAX_PRECISION = 60
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfmt_pkg::cmd_type    cmd,
   output pfmt_pkg::status_type status,
   input  logic [2:0]           req_func,
   input  logic [63:0]          req_value,
   input  logic [1:0]           req_length_mode,
   input  logic [6:0]           req_field_width,
   input  logic                 req_has_width,
   input  logic [5:0]           req_digit_precision,
   input  logic                 req_has_precision,
   input  logic [1:0]           req_sign_mode,
   input  logic                 req_left_justify,
   input  logic                 req_zero_pad,
   input  logic                 req_alt_form,
   output logic [7:0]           char_out
);

   // request latch
   logic [2:0]  func_ff;
   logic [6:0]  fw_ff;
   logic [5:0]  pr_ff;
   logic        hp_ff, lj_ff, zp_ff, af_ff, upper_ff;
   logic [1:0]  sm_ff;
   logic        oct_ff;
   logic        neg_ff, magnz_ff;
   logic [63:0] m_ff;            // binary bits still to shift into bcd_ff
   logic [79:0] bcd_ff;          // digit source, lowest digit at the bottom
   logic [6:0]  dd_cnt_ff;       // BCD shift steps left

   // digit store, written at nd, read at the emit index
   logic [3:0]  dig_mem [0:31];
   logic [5:0]  nd_ff;
   logic        skip_ff;

   // plan
   logic [6:0]  pad_ff, zeros_ff, len_ff;
   logic        has_sign_ff, has_pfx_ff;
   logic [7:0]  sign_ch_ff;

   // emit
   pfmt_pkg::seg_type seg_ff;
   logic [6:0]  cnt_ff;          // items left in current segment
   logic [6:0]  emitted_ff;
   logic [5:0]  didx_ff;
   logic [5:0]  didx_in;
   logic [3:0]  dig_rd_ff;

   // ---------------- load: magnitude ----------------
   logic [63:0] mag_in;
   logic        neg_in;
   logic [6:0]  fw_in;
   logic [5:0]  pr_in;
   logic        skip_in;
   always_comb begin
      neg_in = 1'b0;
      mag_in = 64'd0;
      if (req_func == pfmt_pkg::FUNC_SDEC) begin
         case (req_length_mode)
            pfmt_pkg::LEN_SHORT: begin
               neg_in = req_value[15];
               mag_in = {48'd0, neg_in ? 16'(-req_value[15:0]) : req_value[15:0]};
            end
            pfmt_pkg::LEN_LONG: begin
               neg_in = req_value[63];
               mag_in = neg_in ? -req_value : req_value;
            end
            default: begin
               neg_in = req_value[31];
               mag_in = {32'd0, neg_in ? 32'(-req_value[31:0]) : req_value[31:0]};
            end
         endcase
      end else if (req_func == pfmt_pkg::FUNC_PTR) begin
         mag_in = req_value;
      end else begin
         case (req_length_mode)
            pfmt_pkg::LEN_SHORT: mag_in = {48'd0, req_value[15:0]};
            pfmt_pkg::LEN_LONG:  mag_in = req_value;
            default:             mag_in = {32'd0, req_value[31:0]};
         endcase
      end
      fw_in = 7'd0;
      if (req_has_width)
         fw_in = (32'(req_field_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : req_field_width;
      pr_in = 6'd0;
      if (req_has_precision)
         pr_in = (32'(req_digit_precision) > MAX_PRECISION) ?
                 6'(MAX_PRECISION) : req_digit_precision;
      skip_in = (mag_in == 64'd0) && req_has_precision && (pr_in == 6'd0);
   end

   // ---------------- conversion step ----------------
   // Decimal first runs 64 shift-and-adjust steps into packed BCD; then
   // every base peels one digit a cycle off the low end of bcd_ff.
   logic [79:0] bcd_adj;
   always_comb begin
      logic [3:0] nib;
      nib = 4'd0;
      for (int k = 0; k < 20; k++) begin
         nib = bcd_ff[4*k +: 4];
         bcd_adj[4*k +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   logic conv_done;
   assign conv_done = cmd.conv_step && (dd_cnt_ff == 7'd0) &&
                      (skip_ff || (nd_ff != 6'd0 && (bcd_ff == 80'd0 || nd_ff == 6'd32)));
   assign status.conv_done = conv_done;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         fw_ff      <= fw_in;
         pr_ff      <= pr_in;
         hp_ff      <= req_has_precision;
         lj_ff      <= req_left_justify;
         zp_ff      <= req_zero_pad;
         af_ff      <= req_alt_form;
         sm_ff      <= req_sign_mode;
         neg_ff     <= neg_in;
         magnz_ff   <= (mag_in != 64'd0);
         m_ff       <= mag_in;
         upper_ff   <= (req_func == pfmt_pkg::FUNC_HEXU);
         oct_ff     <= (req_func == pfmt_pkg::FUNC_OCT);
         case (req_func) inside
            pfmt_pkg::FUNC_OCT, pfmt_pkg::FUNC_HEXL, pfmt_pkg::FUNC_HEXU,
            pfmt_pkg::FUNC_PTR: begin
               bcd_ff    <= {16'd0, mag_in};
               dd_cnt_ff <= 7'd0;
            end
            default: begin
               bcd_ff    <= 80'd0;
               dd_cnt_ff <= skip_in ? 7'd0 : 7'd64;
            end
         endcase
         nd_ff       <= 6'd0;
         skip_ff     <= skip_in;
      end else if (cmd.conv_step && !conv_done) begin
         if (dd_cnt_ff != 7'd0) begin
            bcd_ff    <= {bcd_adj[78:0], m_ff[63]};
            m_ff      <= {m_ff[62:0], 1'b0};
            dd_cnt_ff <= dd_cnt_ff - 7'd1;
         end else begin
            dig_mem[nd_ff[4:0]] <= oct_ff ? {1'b0, bcd_ff[2:0]} : bcd_ff[3:0];
            nd_ff  <= nd_ff + 6'd1;
            bcd_ff <= oct_ff ? {3'd0, bcd_ff[79:3]} : {4'd0, bcd_ff[79:4]};
         end
      end
   end

   // ---------------- plan ----------------
   logic [6:0] zeros_p, content_p, pad_p, zeros_f;
   logic       sign_p, pfx_p;
   logic [7:0] sign_ch_p;
   always_comb begin
      sign_p    = 1'b0;
      sign_ch_p = pfmt_pkg::CHAR_MINUS;
      if (func_ff == pfmt_pkg::FUNC_SDEC) begin
         if (neg_ff) begin
            sign_p = 1'b1;
         end else if (sm_ff == pfmt_pkg::SMODE_FORCE_PLUS) begin
            sign_p = 1'b1; sign_ch_p = pfmt_pkg::CHAR_PLUS;
         end else if (sm_ff == pfmt_pkg::SMODE_BLANK) begin
            sign_p = 1'b1; sign_ch_p = pfmt_pkg::CHAR_SPACE;
         end
      end
      zeros_p = (hp_ff && pr_ff > nd_ff) ? 7'(pr_ff - nd_ff) : 7'd0;
      pfx_p   = 1'b0;
      if (func_ff == pfmt_pkg::FUNC_OCT && af_ff) begin
         if (zeros_p == 7'd0 && (magnz_ff || nd_ff == 6'd0)) zeros_p = 7'd1;
      end else if (func_ff == pfmt_pkg::FUNC_PTR) begin
         pfx_p = 1'b1;
      end else if ((func_ff == pfmt_pkg::FUNC_HEXL || func_ff == pfmt_pkg::FUNC_HEXU)
                   && af_ff && magnz_ff) begin
         pfx_p = 1'b1;
      end
      content_p = 7'(sign_p) + (pfx_p ? 7'd2 : 7'd0) + zeros_p + 7'(nd_ff);
      zeros_f   = zeros_p;
      if (zp_ff && !lj_ff && !hp_ff && fw_ff > content_p) begin
         zeros_f   = zeros_p + (fw_ff - content_p);
         content_p = fw_ff;
      end
      pad_p = (fw_ff > content_p) ? 7'(fw_ff - content_p) : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.plan) begin
         pad_ff      <= pad_p;
         zeros_ff    <= zeros_f;
         has_sign_ff <= sign_p;
         has_pfx_ff  <= pfx_p;
         sign_ch_ff  <= sign_ch_p;
         len_ff      <= content_p + pad_p;
      end
   end
   assign status.is_empty = (len_ff == 7'd0);

   // ---------------- emit sequencer ----------------
   // Finds the first nonempty segment at or after seg s, else SEG_PAD_R.
   function automatic pfmt_pkg::seg_type first_seg(
      input pfmt_pkg::seg_type s, input logic lj, input logic [6:0] pad,
      input logic sg, input logic pf, input logic [6:0] zr, input logic [5:0] nd);
      pfmt_pkg::seg_type r;
      r = pfmt_pkg::SEG_PAD_R;
      if (s <= pfmt_pkg::SEG_PAD_L && !lj && pad != 7'd0)       r = pfmt_pkg::SEG_PAD_L;
      else if (s <= pfmt_pkg::SEG_SIGN && sg)                    r = pfmt_pkg::SEG_SIGN;
      else if (s <= pfmt_pkg::SEG_PREFIX && pf)                  r = pfmt_pkg::SEG_PREFIX;
      else if (s <= pfmt_pkg::SEG_ZEROS && zr != 7'd0)           r = pfmt_pkg::SEG_ZEROS;
      else if (s <= pfmt_pkg::SEG_DIGITS && nd != 6'd0)          r = pfmt_pkg::SEG_DIGITS;
      return r;
   endfunction

   function automatic logic [6:0] seg_len(
      input pfmt_pkg::seg_type s, input logic [6:0] pad, input logic [6:0] zr,
      input logic [5:0] nd);
      logic [6:0] r;
      case (s) inside
         pfmt_pkg::SEG_PAD_L, pfmt_pkg::SEG_PAD_R: r = pad;
         pfmt_pkg::SEG_SIGN:   r = 7'd1;
         pfmt_pkg::SEG_PREFIX: r = 7'd2;
         pfmt_pkg::SEG_ZEROS:  r = zr;
         default:              r = 7'(nd);
      endcase
      return r;
   endfunction

   pfmt_pkg::seg_type nseg;
   always_comb begin
      nseg = pfmt_pkg::SEG_PAD_R;
      case (seg_ff)
         pfmt_pkg::SEG_PAD_L:  nseg = first_seg(pfmt_pkg::SEG_SIGN, lj_ff, pad_ff,
                                     has_sign_ff, has_pfx_ff, zeros_ff, nd_ff);
         pfmt_pkg::SEG_SIGN:   nseg = first_seg(pfmt_pkg::SEG_PREFIX, lj_ff, pad_ff,
                                     has_sign_ff, has_pfx_ff, zeros_ff, nd_ff);
         pfmt_pkg::SEG_PREFIX: nseg = first_seg(pfmt_pkg::SEG_ZEROS, lj_ff, pad_ff,
                                     has_sign_ff, has_pfx_ff, zeros_ff, nd_ff);
         pfmt_pkg::SEG_ZEROS:  nseg = first_seg(pfmt_pkg::SEG_DIGITS, lj_ff, pad_ff,
                                     has_sign_ff, has_pfx_ff, zeros_ff, nd_ff);
         default:              nseg = pfmt_pkg::SEG_PAD_R;
      endcase
   end

   pfmt_pkg::seg_type sseg;
   assign sseg = first_seg(pfmt_pkg::SEG_PAD_L, lj_ff, pad_ff, has_sign_ff,
                           has_pfx_ff, zeros_ff, nd_ff);

   // next digit index; the store is read at that address into a register, ahead of use
   always_comb begin
      didx_in = didx_ff;
      if (cmd.emit_start)
         didx_in = nd_ff - 6'd1;
      else if (cmd.emit_step && seg_ff == pfmt_pkg::SEG_DIGITS)
         didx_in = didx_ff - 6'd1;
   end

   always_ff @(posedge clock) begin
      dig_rd_ff <= dig_mem[didx_in[4:0]];
   end

   always_comb begin
      case (seg_ff) inside
         pfmt_pkg::SEG_PAD_L, pfmt_pkg::SEG_PAD_R: char_out = pfmt_pkg::CHAR_SPACE;
         pfmt_pkg::SEG_SIGN:   char_out = sign_ch_ff;
         pfmt_pkg::SEG_PREFIX: char_out = (cnt_ff == 7'd2) ? pfmt_pkg::CHAR_ZERO :
                                          (upper_ff ? pfmt_pkg::CHAR_UPX : pfmt_pkg::CHAR_LOWX);
         pfmt_pkg::SEG_ZEROS:  char_out = pfmt_pkg::CHAR_ZERO;
         default: char_out = (dig_rd_ff < 4'd10) ? (pfmt_pkg::CHAR_ZERO + 8'(dig_rd_ff)) :
                             ((upper_ff ? pfmt_pkg::CHAR_AUP : pfmt_pkg::CHAR_ALOW)
                              + 8'(dig_rd_ff));
      endcase
   end

   assign status.emit_last = (emitted_ff + 7'd1 == len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff     <= pfmt_pkg::SEG_PAD_L;
         cnt_ff     <= 7'd0;
         emitted_ff <= 7'd0;
         didx_ff    <= 6'd0;
      end else begin
         didx_ff <= didx_in;
         if (cmd.emit_start) begin
            seg_ff     <= sseg;
            cnt_ff     <= seg_len(sseg, pad_ff, zeros_ff, nd_ff);
            emitted_ff <= 7'd0;
         end else if (cmd.emit_step) begin
            emitted_ff <= emitted_ff + 7'd1;
            if (cnt_ff == 7'd1) begin
               seg_ff <= nseg;
               cnt_ff <= seg_len(nseg, pad_ff, zeros_ff, nd_ff);
            end else begin
               cnt_ff <= cnt_ff - 7'd1;
            end
         end
      end
   end

endmodule

[hdl/pfmt_ctrl.sv]
// ----------------------------------------------------------------------------
// pfmt_ctrl
// Sequencer: accepts a request, runs digit conversion, plans the field
// and steps the emitter as the result channel takes characters.
// ----------------------------------------------------------------------------
module pfmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 empty_out,
   output pfmt_pkg::cmd_type    cmd,
   input  pfmt_pkg::status_type status
);

   pfmt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfmt_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      empty_out = 1'b0;
      unique case (state_ff)
         pfmt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pfmt_pkg::ST_CONV;
            end
         end
         pfmt_pkg::ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) state_in = pfmt_pkg::ST_PLAN;
         end
         pfmt_pkg::ST_PLAN: begin
            // plan registers land this cycle; start the emitter next
            cmd.plan = 1'b1;
            state_in = pfmt_pkg::ST_EMPTY;
         end
         pfmt_pkg::ST_EMPTY: begin
            if (status.is_empty) begin
               rsp_valid = 1'b1;
               empty_out = 1'b1;
               if (rsp_ready) state_in = pfmt_pkg::ST_IDLE;
            end else begin
               cmd.emit_start = 1'b1;
               state_in = pfmt_pkg::ST_EMIT;
            end
         end
         pfmt_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) state_in = pfmt_pkg::ST_IDLE;
            end
         end
         default: state_in = pfmt_pkg::ST_IDLE;
      endcase
   end

endmodule
